FILE: sv/nup_pkg.sv
// shared types, constants and helper functions of the nmea utc sentence parser
package nup_pkg;

    localparam int unsigned MAX_SENTENCE_LEN = 82;
    localparam logic [7:0]  MAX_LEN_B        = 8'(MAX_SENTENCE_LEN);
    localparam logic [7:0]  MIN_TRIM_LEN     = 8'd7;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_FIX_A  = 8'h41;

    localparam logic [23:0] TYPE_RMC = 24'h524D43;
    localparam logic [23:0] TYPE_ZDA = 24'h5A4441;

    localparam logic [3:0] FLD_TYPE  = 4'd0;
    localparam logic [3:0] FLD_TIME  = 4'd1;
    localparam logic [3:0] FLD_STAT  = 4'd2;
    localparam logic [3:0] FLD_MONTH = 4'd3;
    localparam logic [3:0] FLD_YEAR  = 4'd4;
    localparam logic [3:0] FLD_DATE  = 4'd9;
    localparam logic [3:0] FLD_SAT   = 4'hF;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_MALFORMED   = 3'd1,
        ST_TOO_LONG    = 3'd2,
        ST_BAD_CKSUM   = 3'd3,
        ST_UNSUPPORTED = 3'd4,
        ST_NO_FIX      = 3'd5,
        ST_RANGE       = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0]  cnt;
        logic        start_bad;
        logic        nul_bad;
        logic [7:0]  trim;
        logic        star_seen;
        logic [7:0]  star_pos;
        logic [7:0]  xsum;
        logic [7:0]  h1;
        logic [7:0]  h2;
        logic [3:0]  fn;
        logic [7:0]  f0_len;
        logic [23:0] f0_tail;
        logic [7:0]  t_len;
        logic        t_dot;
        logic        t_fmt_bad;
        logic        t_frac_bad;
        logic [1:0]  t_frac_n;
        logic [6:0]  t_hh;
        logic [6:0]  t_mm;
        logic [6:0]  t_ss;
        logic [9:0]  t_ms;
        logic [7:0]  f2_len;
        logic [7:0]  f2_ch;
        logic [5:0]  z_day;
        logic        z_day_nd;
        logic [7:0]  f3_len;
        logic [3:0]  z_mon;
        logic        z_mon_nd;
        logic [7:0]  f4_len;
        logic [16:0] z_year;
        logic        z_year_nd;
        logic [15:0] z_ydig;
        logic [7:0]  f9_len;
        logic        f9_bad;
        logic [6:0]  d_dd;
        logic [6:0]  d_mm;
        logic [6:0]  d_yy;
    } t_scan;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    // two-digit decimal accumulate
    function automatic logic [6:0] acc2(input logic [6:0] v, input logic [3:0] d,
                                        input logic first);
        return first ? {3'b000, d} : 7'(v * 7'd10 + {3'b000, d});
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_nib(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, c[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end
        return 5'b0_0000;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m);
        case (m)
            4'd2:                      return 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
            default:                   return 5'd31;
        endcase
    endfunction

endpackage

FILE: sv/nup_if.sv
// byte stream and result channel interfaces
interface nup_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_line;
    modport source(output valid, char_in, end_of_line, input ready);
    modport sink(input valid, char_in, end_of_line, output ready);
endinterface

interface nup_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    modport source(output valid, status, hour, minute, second, millisecond, day, month,
                   year, input ready);
    modport sink(input valid, status, hour, minute, second, millisecond, day, month, year,
                 output ready);
endinterface

FILE: sv/nup_scan.sv
// per-byte line scanner: length, checksum and field state of the current line
module nup_scan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic [7:0]     i_char,
    input  logic           i_eol,
    output nup_pkg::t_scan o_next
);

    nup_pkg::t_scan r_scan;
    nup_pkg::t_scan n_scan;

    always_comb begin
        logic [7:0]  p;
        logic [7:0]  c;
        logic [7:0]  k;
        logic        dig;
        logic [3:0]  d;
        logic [8:0]  t_day;
        logic [7:0]  t_mon;
        logic [19:0] t_year;
        n_scan = r_scan;
        p      = r_scan.cnt;
        c      = i_char;
        dig    = nup_pkg::is_digit(c);
        d      = c[3:0];
        k      = 8'd0;
        t_day  = 9'(r_scan.z_day * 9'd10 + {5'b0, d});
        t_mon  = 8'(r_scan.z_mon * 8'd10 + {4'b0, d});
        t_year = 20'(r_scan.z_year * 20'd10 + {16'b0, d});

        n_scan.cnt = nup_pkg::sat_inc8(r_scan.cnt);
        if (p == 8'd0) begin
            n_scan.start_bad = (c != nup_pkg::CH_DOLLAR);
        end
        if (p == 8'd1) begin
            n_scan.nul_bad = (c == nup_pkg::CH_NUL);
        end
        if (c != nup_pkg::CH_CR && c != nup_pkg::CH_LF) begin
            n_scan.trim = p + 8'd1;
        end

        if (p != 8'd0 && !r_scan.star_seen) begin
            if (c == nup_pkg::CH_STAR) begin
                n_scan.star_seen = 1'b1;
                n_scan.star_pos  = p;
            end else begin
                n_scan.xsum = r_scan.xsum ^ c;
                if (c == nup_pkg::CH_COMMA) begin
                    if (r_scan.fn != nup_pkg::FLD_SAT) begin
                        n_scan.fn = r_scan.fn + 4'd1;
                    end
                end else begin
                    case (r_scan.fn)
                        nup_pkg::FLD_TYPE: begin
                            n_scan.f0_len  = nup_pkg::sat_inc8(r_scan.f0_len);
                            n_scan.f0_tail = {r_scan.f0_tail[15:0], c};
                        end
                        nup_pkg::FLD_TIME: begin
                            k            = r_scan.t_len;
                            n_scan.t_len = nup_pkg::sat_inc8(k);
                            if (!r_scan.t_dot) begin
                                if (c == nup_pkg::CH_DOT) begin
                                    n_scan.t_dot = 1'b1;
                                    if (k != 8'd6) begin
                                        n_scan.t_fmt_bad = 1'b1;
                                    end
                                end else if (k >= 8'd6 || !dig) begin
                                    n_scan.t_fmt_bad = 1'b1;
                                end else begin
                                    case (k[2:0])
                                        3'd0, 3'd1: n_scan.t_hh =
                                            nup_pkg::acc2(r_scan.t_hh, d, ~k[0]);
                                        3'd2, 3'd3: n_scan.t_mm =
                                            nup_pkg::acc2(r_scan.t_mm, d, ~k[0]);
                                        3'd4, 3'd5: n_scan.t_ss =
                                            nup_pkg::acc2(r_scan.t_ss, d, ~k[0]);
                                        default: ;
                                    endcase
                                end
                            end else begin
                                if (!dig) begin
                                    n_scan.t_frac_bad = 1'b1;
                                end else if (r_scan.t_frac_n != 2'd3) begin
                                    n_scan.t_ms = 10'(r_scan.t_ms * 10'd10 + {6'b0, d});
                                end
                                if (r_scan.t_frac_n != 2'd3) begin
                                    n_scan.t_frac_n = r_scan.t_frac_n + 2'd1;
                                end
                            end
                        end
                        nup_pkg::FLD_STAT: begin
                            n_scan.f2_len = nup_pkg::sat_inc8(r_scan.f2_len);
                            if (r_scan.f2_len == 8'd0) begin
                                n_scan.f2_ch = c;
                            end
                            if (!dig) begin
                                n_scan.z_day_nd = 1'b1;
                            end else begin
                                n_scan.z_day = (t_day > 9'd32) ? 6'd32 : t_day[5:0];
                            end
                        end
                        nup_pkg::FLD_MONTH: begin
                            n_scan.f3_len = nup_pkg::sat_inc8(r_scan.f3_len);
                            if (!dig) begin
                                n_scan.z_mon_nd = 1'b1;
                            end else begin
                                n_scan.z_mon = (t_mon > 8'd13) ? 4'd13 : t_mon[3:0];
                            end
                        end
                        nup_pkg::FLD_YEAR: begin
                            n_scan.f4_len = nup_pkg::sat_inc8(r_scan.f4_len);
                            if (!dig) begin
                                n_scan.z_year_nd = 1'b1;
                            end else begin
                                n_scan.z_year = (t_year > 20'd65536) ? 17'd65536 :
                                                t_year[16:0];
                                n_scan.z_ydig = {r_scan.z_ydig[11:0], d};
                            end
                        end
                        nup_pkg::FLD_DATE: begin
                            k             = r_scan.f9_len;
                            n_scan.f9_len = nup_pkg::sat_inc8(k);
                            if (k < 8'd6) begin
                                if (!dig) begin
                                    n_scan.f9_bad = 1'b1;
                                end else begin
                                    case (k[2:0])
                                        3'd0, 3'd1: n_scan.d_dd =
                                            nup_pkg::acc2(r_scan.d_dd, d, ~k[0]);
                                        3'd2, 3'd3: n_scan.d_mm =
                                            nup_pkg::acc2(r_scan.d_mm, d, ~k[0]);
                                        3'd4, 3'd5: n_scan.d_yy =
                                            nup_pkg::acc2(r_scan.d_yy, d, ~k[0]);
                                        default: ;
                                    endcase
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end else if (r_scan.star_seen) begin
            if (p == r_scan.star_pos + 8'd1) begin
                n_scan.h1 = c;
            end
            if (p == r_scan.star_pos + 8'd2) begin
                n_scan.h2 = c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_fire) begin
            if (i_eol) begin
                r_scan <= '0;
            end else begin
                r_scan <= n_scan;
            end
        end
    end

    assign o_next = n_scan;

    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_eol) |=> (r_scan.cnt == 8'd0 && !r_scan.star_seen))
        else $error("scanner state not cleared after end of line");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_eol && r_scan.cnt == 8'hFF) |=> (r_scan.cnt == 8'hFF))
        else $error("byte count wrapped");

endmodule

FILE: sv/nup_eval.sv
// end-of-line checks, calendar validation and result register
module nup_eval (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  nup_pkg::t_scan   i_scan,
    output logic             o_free,
    nup_res_if.source        o_res
);

    logic             r_valid;
    nup_pkg::t_status r_status;
    logic [4:0]       r_hour;
    logic [5:0]       r_minute;
    logic [5:0]       r_second;
    logic [9:0]       r_ms;
    logic [4:0]       r_day;
    logic [3:0]       r_month;
    logic [15:0]      r_year;

    nup_pkg::t_status n_status;
    logic [9:0]       n_ms;
    logic [6:0]       n_day;
    logic [6:0]       n_month;
    logic [15:0]      n_year;

    always_comb begin
        logic [4:0] hx1;
        logic [4:0] hx2;
        logic       rmc;
        logic       zda;
        logic       t_fmt;
        logic       t_frac;
        logic       leap;
        logic       c100;
        logic [4:0] q;
        logic [4:0] dim;
        logic       zda_bad;
        hx1    = nup_pkg::hex_nib(i_scan.h1);
        hx2    = nup_pkg::hex_nib(i_scan.h2);
        rmc    = (i_scan.f0_tail == nup_pkg::TYPE_RMC);
        zda    = (i_scan.f0_tail == nup_pkg::TYPE_ZDA);
        t_fmt  = i_scan.t_fmt_bad || (!i_scan.t_dot && i_scan.t_len != 8'd6);
        t_frac = i_scan.t_frac_bad || (i_scan.t_dot && i_scan.t_frac_n == 2'd0);

        case (i_scan.t_frac_n)
            2'd1:    n_ms = 10'(i_scan.t_ms * 10'd100);
            2'd2:    n_ms = 10'(i_scan.t_ms * 10'd10);
            default: n_ms = i_scan.t_ms;
        endcase

        c100 = (i_scan.z_ydig[7:0] == 8'h00);
        q    = 5'({1'b0, i_scan.z_ydig[15:12]} * 5'd2 + {1'b0, i_scan.z_ydig[11:8]});
        if (rmc) begin
            n_day   = i_scan.d_dd;
            n_month = i_scan.d_mm;
            n_year  = (i_scan.d_yy >= 7'd80) ? 16'd1900 + {9'b0, i_scan.d_yy} :
                                               16'd2000 + {9'b0, i_scan.d_yy};
            leap    = (i_scan.d_yy[1:0] == 2'b00);
        end else begin
            n_day   = {1'b0, i_scan.z_day};
            n_month = {3'b000, i_scan.z_mon};
            n_year  = i_scan.z_year[15:0];
            leap    = (i_scan.z_year[1:0] == 2'b00 && !c100) || (c100 && q[1:0] == 2'b00);
        end
        dim = (n_month == 7'd2 && leap) ? 5'd29 : nup_pkg::month_len(n_month[3:0]);

        zda_bad = i_scan.fn < nup_pkg::FLD_YEAR
               || i_scan.f2_len == 8'd0 || i_scan.z_day_nd || i_scan.z_day > 6'd31
               || i_scan.f3_len == 8'd0 || i_scan.z_mon_nd || i_scan.z_mon > 4'd12
               || i_scan.f4_len == 8'd0 || i_scan.z_year_nd || i_scan.z_year > 17'd65535;

        if (i_scan.cnt > nup_pkg::MAX_LEN_B) begin
            n_status = nup_pkg::ST_TOO_LONG;
        end else if (i_scan.start_bad) begin
            n_status = nup_pkg::ST_MALFORMED;
        end else if (i_scan.trim < nup_pkg::MIN_TRIM_LEN || i_scan.nul_bad) begin
            n_status = nup_pkg::ST_MALFORMED;
        end else if (!i_scan.star_seen
                     || ({1'b0, i_scan.star_pos} + 9'd3) != {1'b0, i_scan.trim}
                     || !hx1[4] || !hx2[4] || i_scan.xsum != {hx1[3:0], hx2[3:0]}) begin
            n_status = nup_pkg::ST_BAD_CKSUM;
        end else if (i_scan.f0_len != 8'd5 || !(rmc || zda)) begin
            n_status = nup_pkg::ST_UNSUPPORTED;
        end else if (i_scan.fn < nup_pkg::FLD_TIME || t_fmt) begin
            n_status = nup_pkg::ST_MALFORMED;
        end else if (i_scan.t_hh > 7'd23 || i_scan.t_mm > 7'd59 || i_scan.t_ss > 7'd59) begin
            n_status = nup_pkg::ST_RANGE;
        end else if (t_frac) begin
            n_status = nup_pkg::ST_MALFORMED;
        end else if (rmc && (i_scan.fn < nup_pkg::FLD_STAT || i_scan.f2_len != 8'd1)) begin
            n_status = nup_pkg::ST_MALFORMED;
        end else if (rmc && i_scan.f2_ch != nup_pkg::CH_FIX_A) begin
            n_status = nup_pkg::ST_NO_FIX;
        end else if (rmc && (i_scan.fn < nup_pkg::FLD_DATE || i_scan.f9_len != 8'd6
                             || i_scan.f9_bad)) begin
            n_status = nup_pkg::ST_MALFORMED;
        end else if (!rmc && zda_bad) begin
            n_status = nup_pkg::ST_RANGE;
        end else if (n_year == 16'd0 || n_month == 7'd0 || n_month > 7'd12
                     || n_day == 7'd0 || n_day > {2'b00, dim}) begin
            n_status = nup_pkg::ST_RANGE;
        end else begin
            n_status = nup_pkg::ST_OK;
        end
    end

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= n_status;
            if (n_status == nup_pkg::ST_OK) begin
                r_hour   <= i_scan.t_hh[4:0];
                r_minute <= i_scan.t_mm[5:0];
                r_second <= i_scan.t_ss[5:0];
                r_ms     <= n_ms;
                r_day    <= n_day[4:0];
                r_month  <= n_month[3:0];
                r_year   <= n_year;
            end else begin
                r_hour   <= '0;
                r_minute <= '0;
                r_second <= '0;
                r_ms     <= '0;
                r_day    <= '0;
                r_month  <= '0;
                r_year   <= '0;
            end
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.status      = r_status;
    assign o_res.hour        = r_hour;
    assign o_res.minute      = r_minute;
    assign o_res.second      = r_second;
    assign o_res.millisecond = r_ms;
    assign o_res.day         = r_day;
    assign o_res.month       = r_month;
    assign o_res.year        = r_year;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result loaded over a pending result");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != nup_pkg::ST_OK) |->
        (r_hour == 5'd0 && r_day == 5'd0 && r_month == 4'd0 && r_year == 16'd0
         && r_ms == 10'd0))
        else $error("error result carries nonzero fields");

endmodule

FILE: sv/nmea_utc_sentence_parser.sv
// top level of the nmea rmc/zda utc sentence parser
//
//  channel  | dir | payload                                      | transfer
//  ---------+-----+----------------------------------------------+-------------------
//  i_byte   | in  | char_in, end_of_line                         | valid && ready
//  o_res    | out | status, hour..millisecond, day, month, year  | valid && ready
//
// one byte per cycle while no result stalls: input register, per-byte scanner, then
// the result register, which holds a valid result once the end-of-line byte is loaded
// synchronous active-low reset clears the line state and both valid flags
// a stalled result only holds back an end-of-line byte; other bytes keep flowing
module nmea_utc_sentence_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nup_byte_if.sink  i_byte,
    nup_res_if.source o_res
);

    logic           r_in_valid;
    logic [7:0]     r_in_char;
    logic           r_in_eol;
    logic           w_fire;
    logic           w_out_free;
    nup_pkg::t_scan w_scan;

    assign w_fire       = r_in_valid && (!r_in_eol || w_out_free);
    assign i_byte.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_char <= i_byte.char_in;
            r_in_eol  <= i_byte.end_of_line;
        end
    end

    nup_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_char  (r_in_char),
        .i_eol   (r_in_eol),
        .o_next  (w_scan)
    );

    nup_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire && r_in_eol),
        .i_scan  (w_scan),
        .o_free  (w_out_free),
        .o_res   (o_res)
    );

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> (r_in_valid && $stable(r_in_char) && $stable(r_in_eol)))
        else $error("input register lost a byte while stalled");

endmodule
